### sv/i2cm_pkg.sv
// Shared types, codes and the step-to-operation table of the I2C master byte engine.
// No dependencies; all other files import this package.
`default_nettype none

package i2cm_pkg;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 2'd1;
    localparam logic [15:0] PHASE_TICKS_RESET   = 16'd5;
    localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Bit counter: eight data bits, then the acknowledge slot
    localparam logic [3:0] BIT_LAST_DATA = 4'd7;
    localparam logic [3:0] BIT_ACK_SLOT  = 4'd8;

    // Raw command codes on the input channel
    localparam logic [2:0] CODE_TICK  = 3'd0;
    localparam logic [2:0] CODE_START = 3'd1;
    localparam logic [2:0] CODE_STOP  = 3'd2;
    localparam logic [2:0] CODE_WRITE = 3'd3;
    localparam logic [2:0] CODE_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCL_LOW,
        OP_SCL_REL,
        OP_SDA_LOW,
        OP_SDA_REL,
        OP_SDA_BIT,
        OP_DELAY,
        OP_POLL,
        OP_SAMPLE
    } op_t;

    typedef enum logic [4:0] {
        STEP_IDLE       = 5'd0,
        STEP_ST_SDA_REL = 5'd1,
        STEP_ST_SCL_REL = 5'd2,
        STEP_ST_DLY0    = 5'd3,
        STEP_ST_SDA_LOW = 5'd4,
        STEP_ST_DLY1    = 5'd5,
        STEP_ST_SCL_LOW = 5'd6,
        STEP_SP_SCL_LOW = 5'd7,
        STEP_SP_DLY0    = 5'd8,
        STEP_SP_SDA_LOW = 5'd9,
        STEP_SP_DLY1    = 5'd10,
        STEP_SP_SCL_REL = 5'd11,
        STEP_SP_DLY2    = 5'd12,
        STEP_SP_SDA_REL = 5'd13,
        STEP_SP_DLY3    = 5'd14,
        STEP_WB_SDA     = 5'd15,
        STEP_WB_DLY0    = 5'd16,
        STEP_WB_SCL_REL = 5'd17,
        STEP_WB_POLL    = 5'd18,
        STEP_WB_DLY1    = 5'd19,
        STEP_WB_SCL_LOW = 5'd20,
        STEP_RB_SDA_REL = 5'd21,
        STEP_RB_DLY0    = 5'd22,
        STEP_RB_SCL_REL = 5'd23,
        STEP_RB_POLL    = 5'd24,
        STEP_RB_DLY1    = 5'd25,
        STEP_RB_SAMPLE  = 5'd26,
        STEP_RB_SCL_LOW = 5'd27,
        STEP_FIN        = 5'd28
    } step_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       read_ack;
        logic       scl_in;
        logic       sda_in;
    } cmd_in_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] received_byte;
        logic       nack_seen;
        logic       stretch_timeout;
        logic       rejected;
    } res_t;

    // Classified beat held in the queue
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data_byte;
        logic       read_ack;
        logic       scl_in;
        logic       sda_in;
    } q_item_t;

    // Pin operation performed at each sequence step
    function automatic op_t step_op(input step_t s);
        op_t op;
        unique case (s)
            STEP_ST_SDA_REL, STEP_SP_SDA_REL, STEP_RB_SDA_REL: op = OP_SDA_REL;
            STEP_ST_SCL_REL, STEP_SP_SCL_REL, STEP_WB_SCL_REL,
            STEP_RB_SCL_REL:                                   op = OP_SCL_REL;
            STEP_ST_SDA_LOW, STEP_SP_SDA_LOW:                  op = OP_SDA_LOW;
            STEP_ST_SCL_LOW, STEP_SP_SCL_LOW, STEP_WB_SCL_LOW,
            STEP_RB_SCL_LOW:                                   op = OP_SCL_LOW;
            STEP_ST_DLY0, STEP_ST_DLY1, STEP_SP_DLY0, STEP_SP_DLY1,
            STEP_SP_DLY2, STEP_SP_DLY3, STEP_WB_DLY0, STEP_WB_DLY1,
            STEP_RB_DLY0, STEP_RB_DLY1:                        op = OP_DELAY;
            STEP_WB_SDA:                                       op = OP_SDA_BIT;
            STEP_WB_POLL, STEP_RB_POLL:                        op = OP_POLL;
            STEP_RB_SAMPLE:                                    op = OP_SAMPLE;
            default:                                           op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

### sv/i2cm_front.sv
// Front end: decodes the raw command code of each input beat into a command kind.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front (
    input  wire  logic               in_valid,
    output logic                     in_ready,
    input  wire  i2cm_pkg::cmd_in_t  in_data,
    output logic                     push_valid,
    input  wire  logic               push_ready,
    output i2cm_pkg::q_item_t        push_item
);
    import i2cm_pkg::*;

    cmd_kind_t kind;

    // Unknown codes act as plain ticks
    always_comb
    begin
        unique case (in_data.command)
            CODE_START: kind = CMD_START;
            CODE_STOP:  kind = CMD_STOP;
            CODE_WRITE: kind = CMD_WRITE;
            CODE_READ:  kind = CMD_READ;
            default:    kind = CMD_TICK;
        endcase
    end

    assign push_valid          = in_valid;
    assign in_ready            = push_ready;
    assign push_item.kind      = kind;
    assign push_item.data_byte = in_data.data_byte;
    assign push_item.read_ack  = in_data.read_ack;
    assign push_item.scl_in    = in_data.scl_in;
    assign push_item.sda_in    = in_data.sda_in;

endmodule

`default_nettype wire

### sv/i2cm_queue.sv
// Short FIFO of classified beats between the front end and the engine.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_queue (
    input  wire  logic                clk,
    input  wire  logic                rst_n,
    input  wire  logic                push_valid,
    output logic                      push_ready,
    input  wire  i2cm_pkg::q_item_t   push_item,
    output logic                      pop_valid,
    input  wire  logic                pop_ready,
    output i2cm_pkg::q_item_t         pop_item
);
    import i2cm_pkg::*;

    q_item_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### sv/i2cm_engine.sv
// Back end: runs the pin sequencer one tick per popped beat and registers the result.
// Holds the configuration registers. Depends on i2cm_pkg.
`default_nettype none

module i2cm_engine (
    input  wire  logic                          clk,
    input  wire  logic                          rst_n,
    input  wire  logic                          cfg_valid,
    output logic                                cfg_ready,
    input  wire  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  logic [15:0]                   cfg_data,
    input  wire  logic                          pop_valid,
    output logic                                pop_ready,
    input  wire  i2cm_pkg::q_item_t             pop_item,
    output logic                                out_valid,
    input  wire  logic                          out_ready,
    output i2cm_pkg::res_t                      out_data
);
    import i2cm_pkg::*;

    // Configuration
    logic [15:0] phase_ticks_reg;
    logic [15:0] stretch_limit_reg;

    // Sequencer state
    step_t       step_reg, step_next, step_a, step_run;
    logic [15:0] phase_reg, phase_next, phase_a;
    logic [15:0] stretch_reg, stretch_next, stretch_a;
    logic [3:0]  bit_index_reg, bit_index_next, bit_index_a;
    logic [7:0]  shift_reg, shift_next, shift_a;
    logic        drv_scl_reg, drv_scl_next;
    logic        drv_sda_reg, drv_sda_next;
    logic        nack_reg, nack_next, nack_a;
    logic        timeout_reg, timeout_next, timeout_a;
    logic        ack_reg, ack_next;
    logic [7:0]  rx_reg, rx_next;

    // Result register
    logic        out_valid_reg;
    res_t        out_data_reg;
    res_t        res_c;

    logic        pop;
    logic        idle;
    logic        is_cmd;
    logic        active;
    logic        run;
    op_t         op;
    logic        abort;
    logic        tx_bit;
    logic        done_c;
    logic [15:0] wait_val;

    assign cfg_ready = 1'b1;
    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign idle   = (step_reg == STEP_IDLE);
    assign is_cmd = (pop_item.kind != CMD_TICK);

    // Command acceptance: applied before the tick's pin operation
    always_comb
    begin
        step_a      = step_reg;
        phase_a     = phase_reg;
        stretch_a   = stretch_reg;
        bit_index_a = bit_index_reg;
        shift_a     = shift_reg;
        nack_a      = nack_reg;
        timeout_a   = timeout_reg;
        ack_next    = ack_reg;
        if (idle && is_cmd)
        begin
            timeout_a   = 1'b0;
            bit_index_a = '0;
            phase_a     = '0;
            stretch_a   = '0;
            unique case (pop_item.kind)
                CMD_START: step_a = STEP_ST_SDA_REL;
                CMD_STOP:  step_a = STEP_SP_SCL_LOW;
                CMD_WRITE:
                begin
                    nack_a  = 1'b0;
                    shift_a = pop_item.data_byte;
                    step_a  = STEP_WB_SDA;
                end
                CMD_READ:
                begin
                    ack_next = pop_item.read_ack;
                    shift_a  = '0;
                    step_a   = STEP_RB_SDA_REL;
                end
                default: ;
            endcase
        end
    end

    assign active   = (step_a != STEP_IDLE);
    assign run      = active && (phase_a == '0);
    assign op       = step_op(step_a);
    assign abort    = run && (op == OP_POLL) && !pop_item.scl_in
                      && (stretch_a >= stretch_limit_reg);
    assign tx_bit   = (bit_index_a < BIT_ACK_SLOT) ? shift_a[7] : !ack_reg;
    assign wait_val = (phase_ticks_reg == '0) ? '0 : phase_ticks_reg - 16'd1;

    // Next step
    always_comb
    begin
        step_run = step_a;
        if (run)
        begin
            unique case (op)
                OP_NONE: step_run = STEP_FIN;
                OP_POLL: step_run = pop_item.scl_in ? step_t'(step_a + 5'd1) : step_a;
                default: step_run = step_t'(step_a + 5'd1);
            endcase
            if (step_a == STEP_WB_SCL_LOW)
            begin
                if (bit_index_a < BIT_LAST_DATA)
                begin
                    step_run = STEP_WB_SDA;
                end
                else if (bit_index_a == BIT_LAST_DATA)
                begin
                    step_run = STEP_RB_SDA_REL;
                end
                else
                begin
                    step_run = STEP_FIN;
                end
            end
            else if (step_a == STEP_RB_SCL_LOW)
            begin
                if (bit_index_a < BIT_LAST_DATA)
                begin
                    step_run = STEP_RB_SDA_REL;
                end
                else if (bit_index_a == BIT_LAST_DATA)
                begin
                    step_run = STEP_WB_SDA;
                end
                else
                begin
                    step_run = STEP_FIN;
                end
            end
        end
        step_next = step_run;
        if (abort)
        begin
            step_next = STEP_IDLE;
        end
        else if (active && (step_run == STEP_FIN) && (phase_next == '0))
        begin
            step_next = STEP_IDLE;
        end
    end

    // Datapath and status for this tick
    always_comb
    begin
        phase_next     = phase_a;
        stretch_next   = stretch_a;
        bit_index_next = bit_index_a;
        shift_next     = shift_a;
        drv_scl_next   = drv_scl_reg;
        drv_sda_next   = drv_sda_reg;
        nack_next      = nack_a;
        timeout_next   = timeout_a;
        rx_next        = rx_reg;
        if (active)
        begin
            if (phase_a != '0)
            begin
                phase_next = phase_a - 16'd1;
            end
            else
            begin
                unique case (op)
                    OP_SCL_LOW:
                    begin
                        drv_scl_next = 1'b1;
                        phase_next   = wait_val;
                    end
                    OP_SCL_REL:
                    begin
                        drv_scl_next = 1'b0;
                        stretch_next = '0;
                        phase_next   = wait_val;
                    end
                    OP_SDA_LOW:
                    begin
                        drv_sda_next = 1'b1;
                        phase_next   = wait_val;
                    end
                    OP_SDA_REL:
                    begin
                        drv_sda_next = 1'b0;
                        phase_next   = wait_val;
                    end
                    OP_SDA_BIT:
                    begin
                        if (bit_index_a < BIT_ACK_SLOT)
                        begin
                            shift_next = {shift_a[6:0], 1'b0};
                        end
                        drv_sda_next = !tx_bit;
                        phase_next   = wait_val;
                    end
                    OP_DELAY: phase_next = wait_val;
                    OP_POLL:
                    begin
                        if (!pop_item.scl_in && !abort)
                        begin
                            stretch_next = stretch_a + 16'd1;
                            phase_next   = wait_val;
                        end
                    end
                    OP_SAMPLE:
                    begin
                        if (bit_index_a < BIT_ACK_SLOT)
                        begin
                            shift_next = {shift_a[6:0], pop_item.sda_in};
                        end
                        else if (pop_item.sda_in)
                        begin
                            nack_next = 1'b1;
                        end
                        phase_next = wait_val;
                    end
                    default: ;
                endcase
                // Advance the bit counter at the end of each data bit slot
                if (((step_a == STEP_WB_SCL_LOW) || (step_a == STEP_RB_SCL_LOW))
                    && (bit_index_a < BIT_ACK_SLOT))
                begin
                    bit_index_next = bit_index_a + 4'd1;
                end
                if ((step_a == STEP_RB_SCL_LOW) && (bit_index_a == BIT_LAST_DATA))
                begin
                    rx_next = shift_a;
                end
            end
            if (abort)
            begin
                phase_next   = '0;
                timeout_next = 1'b1;
            end
        end
    end

    assign done_c = abort || (active && (step_run == STEP_FIN) && (phase_next == '0));

    assign res_c.scl_pull_low    = drv_scl_next;
    assign res_c.sda_pull_low    = drv_sda_next;
    assign res_c.busy_res        = (step_next != STEP_IDLE);
    assign res_c.done_res        = done_c;
    assign res_c.received_byte   = rx_next;
    assign res_c.nack_seen       = nack_next;
    assign res_c.stretch_timeout = timeout_next;
    assign res_c.rejected        = !idle && is_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg   <= PHASE_TICKS_RESET;
            stretch_limit_reg <= STRETCH_LIMIT_RESET;
            step_reg          <= STEP_IDLE;
            phase_reg         <= '0;
            stretch_reg       <= '0;
            bit_index_reg     <= '0;
            shift_reg         <= '0;
            drv_scl_reg       <= 1'b0;
            drv_sda_reg       <= 1'b0;
            nack_reg          <= 1'b0;
            timeout_reg       <= 1'b0;
            ack_reg           <= 1'b0;
            rx_reg            <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PHASE_TICKS)
                begin
                    phase_ticks_reg <= cfg_data;
                end
                else if (cfg_index == CFG_STRETCH_LIMIT)
                begin
                    stretch_limit_reg <= cfg_data;
                end
            end
            if (pop)
            begin
                step_reg      <= step_next;
                phase_reg     <= phase_next;
                stretch_reg   <= stretch_next;
                bit_index_reg <= bit_index_next;
                shift_reg     <= shift_next;
                drv_scl_reg   <= drv_scl_next;
                drv_sda_reg   <= drv_sda_next;
                nack_reg      <= nack_next;
                timeout_reg   <= timeout_next;
                ack_reg       <= ack_next;
                rx_reg        <= rx_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= res_c;
        end
    end

endmodule

`default_nettype wire

### sv/i2c_master_byte_engine.sv
// I2C master byte engine, top level: front decoder, beat queue and pin sequencer.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_engine.
//
// Usage:
//   Each input beat is one bus tick: the sampled SCL/SDA levels plus an optional
//   command (start, stop, write byte, read byte). Every input beat yields exactly
//   one result beat with the open-drain pull controls and status after that tick.
//   Commands are taken only while the sequencer is idle; a command that arrives
//   while busy is dropped and flagged as rejected on its result beat.
//   Configuration (phase_ticks, stretch_limit) goes through the cfg channel,
//   which is always ready; write it only while no beats are outstanding.
// Timing:
//   A beat accepted by the queue is stored there, popped by the sequencer once the
//   result register can take it, and its result is registered onto out_*.
//   Sustained rate is one beat per cycle while out_ready stays high, set by the single-tick sequencer step.
//   A two-beat queue sits between the front end and the sequencer, and a result
//   register follows the sequencer; when out_ready drops, the sequencer holds and
//   in_ready falls as soon as the queue holds two beats. Nothing is dropped while
//   stalled.
// Reset:
//   rst_n clears the queue and the result valid flag, returns the sequencer to
//   idle with both lines released, and loads phase_ticks 5 and stretch_limit 1000.
`default_nettype none

module i2c_master_byte_engine (
    input  wire  logic                           clk,
    input  wire  logic                           rst_n,
    input  wire  logic                           cfg_valid,
    output logic                                 cfg_ready,
    input  wire  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  logic [15:0]                    cfg_data,
    input  wire  logic                           in_valid,
    output logic                                 in_ready,
    input  wire  i2cm_pkg::cmd_in_t              in_data,
    output logic                                 out_valid,
    input  wire  logic                           out_ready,
    output i2cm_pkg::res_t                       out_data
);
    import i2cm_pkg::*;

    // Front end to queue
    logic    push_valid;
    logic    push_ready;
    q_item_t push_item;

    // Queue to sequencer
    logic    pop_valid;
    logic    pop_ready;
    q_item_t pop_item;

    // Decode the command code of each beat
    i2cm_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouple the input side from result stalls
    i2cm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Run one sequencer tick per beat and hold the result for the receiver
    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A finishing command leaves the engine idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res) |-> !out_data.busy_res)
        else $error("done reported while still busy");

    // A stretch abort happens while polling, with SCL released
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res && out_data.stretch_timeout)
        |-> !out_data.scl_pull_low)
        else $error("stretch abort with SCL still pulled low");

    // Input back-pressure only when beats are waiting in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> pop_valid)
        else $error("input stalled with an empty queue");

    // Popped beats only when the result register can take them
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && pop_valid) |=> $stable(out_data))
        else $error("result overwritten while the receiver stalls");

endmodule

`default_nettype wire
